// ----- hw/rtl/lru_page_replacement_macros.svh -----
// Assertion macros used by the port-level checker of the LRU page replacement block.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LRUPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru_page_replacement check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define LRUPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru_page_replacement check failed");

`endif

// ----- hw/rtl/lrupr_pkg.sv -----
// Package with the sizes, register codes and types of the LRU page replacement block.
package lrupr_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int PAGE_BITS  = 16;

    localparam int PAGE_NUM_W = 16;
    localparam int FAULT_W    = 32;
    localparam int LIMIT_W    = 4;
    localparam int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = REG_IDX_W'(0);
    localparam logic [LIMIT_W-1:0]   FRAMES_RESET      = LIMIT_W'(8);

    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [SLOT_W-1:0]    t_age;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [FAULT_W-1:0]   t_fault;

endpackage

// ----- hw/rtl/lru_page_replacement.sv -----
// Fully associative LRU page frame store with fault counting and an APB register port.
// Each page request is captured in an input register, looked up against all frames,
// applied to the frame state and written to a result register; it waits in the input
// register while the output stalls. The block sustains one request per cycle while the
// output is not stalled. The parallel page compare and age-rank update over all frames
// are combinational. The frames_in_use register at byte address 0 limits how many frames
// are filled before eviction starts; a request with start_run set clears the frames and
// the fault count before it is looked up. Configuration must be written by the user only
// while no request is in flight; the block itself does not enforce this.
module lru_page_replacement (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [lrupr_pkg::PAGE_NUM_W-1:0]     i_page_number,
    input  logic                                 i_start_run,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_page_fault,
    output logic                                 o_victim_valid,
    output logic [lrupr_pkg::PAGE_NUM_W-1:0]     o_victim_page,
    output logic [lrupr_pkg::FAULT_W-1:0]        o_fault_count,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lrupr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lrupr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lrupr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);

    logic [lrupr_pkg::LIMIT_W-1:0]       r_frames;
    logic [lrupr_pkg::REG_IDX_W-1:0]     reg_idx;

    logic                                r_in_valid;
    lrupr_pkg::t_page                    r_in_page;
    logic                                r_in_start;

    logic [lrupr_pkg::MAX_FRAMES-1:0]    r_valid;
    lrupr_pkg::t_age                     r_age [lrupr_pkg::MAX_FRAMES];
    lrupr_pkg::t_page                    r_page [lrupr_pkg::MAX_FRAMES];
    lrupr_pkg::t_fault                   r_fault;

    logic                                r_out_valid;
    logic                                r_out_fault;
    logic                                r_out_victim_valid;
    logic [lrupr_pkg::PAGE_NUM_W-1:0]    r_out_victim_page;
    lrupr_pkg::t_fault                   r_out_count;

    logic                                advance;
    logic                                process;
    logic                                accept;

    logic [lrupr_pkg::MAX_FRAMES-1:0]    eff_valid;
    lrupr_pkg::t_age                     eff_age [lrupr_pkg::MAX_FRAMES];
    lrupr_pkg::t_fault                   eff_fault;
    lrupr_pkg::t_count                   eff_limit;
    lrupr_pkg::t_count                   resident;
    logic [lrupr_pkg::MAX_FRAMES-1:0]    hit_vec;
    logic [lrupr_pkg::MAX_FRAMES-1:0]    lru_vec;
    logic                                hit_any;
    logic                                lru_any;
    logic                                free_any;
    lrupr_pkg::t_slot                    hit_slot;
    lrupr_pkg::t_slot                    lru_slot;
    lrupr_pkg::t_slot                    free_slot;
    lrupr_pkg::t_slot                    slot;
    logic                                do_fill;
    logic                                do_evict;
    logic                                do_touch;
    lrupr_pkg::t_count                   touch_lim;

    logic [lrupr_pkg::MAX_FRAMES-1:0]    n_valid;
    lrupr_pkg::t_age                     n_age [lrupr_pkg::MAX_FRAMES];
    lrupr_pkg::t_fault                   n_fault;
    logic [lrupr_pkg::PAGE_NUM_W-1:0]    n_victim_page;

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_idx = paddr[lrupr_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= lrupr_pkg::FRAMES_RESET;
        end else if (psel && penable && pwrite && pready
                     && reg_idx == lrupr_pkg::REG_FRAMES_IN_USE) begin
            r_frames <= pwdata[lrupr_pkg::LIMIT_W-1:0];
        end
    end

    always_comb begin
        if (reg_idx == lrupr_pkg::REG_FRAMES_IN_USE) begin
            prdata = lrupr_pkg::APB_DATA_W'(r_frames);
        end else begin
            prdata = '0;
        end
    end

    // Request handshake.
    assign advance    = !r_out_valid || !i_out_stall;
    assign process    = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_page  <= lrupr_pkg::PAGE_BITS'(i_page_number);
            r_in_start <= i_start_run;
        end
    end

    // Lookup and replacement decision.
    always_comb begin
        eff_valid = r_in_start ? '0 : r_valid;
        eff_fault = r_in_start ? '0 : r_fault;
        for (int i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
            eff_age[i] = r_in_start ? '0 : r_age[i];
        end

        if (r_frames == '0) begin
            eff_limit = lrupr_pkg::COUNT_W'(1);
        end else if (int'(r_frames) > lrupr_pkg::MAX_FRAMES) begin
            eff_limit = lrupr_pkg::COUNT_W'(lrupr_pkg::MAX_FRAMES);
        end else begin
            eff_limit = lrupr_pkg::COUNT_W'(r_frames);
        end

        resident = '0;
        for (int i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
            resident = resident + lrupr_pkg::COUNT_W'(eff_valid[i]);
        end

        free_any  = 1'b0;
        free_slot = '0;
        for (int i = lrupr_pkg::MAX_FRAMES - 1; i >= 0; i--) begin
            if (!eff_valid[i]) begin
                free_any  = 1'b1;
                free_slot = lrupr_pkg::SLOT_W'(i);
            end
        end

        hit_slot = '0;
        lru_slot = '0;
        for (int i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
            hit_vec[i] = eff_valid[i] && (r_page[i] == r_in_page);
            lru_vec[i] = eff_valid[i]
                         && (lrupr_pkg::COUNT_W'(eff_age[i]) == resident - 1'b1);
            if (hit_vec[i]) begin
                hit_slot = hit_slot | lrupr_pkg::SLOT_W'(i);
            end
            if (lru_vec[i]) begin
                lru_slot = lru_slot | lrupr_pkg::SLOT_W'(i);
            end
        end
        hit_any = |hit_vec;
        lru_any = |lru_vec;

        do_fill  = !hit_any && (resident < eff_limit) && free_any;
        do_evict = !hit_any && !do_fill && lru_any;
        do_touch = hit_any || do_fill || do_evict;

        if (hit_any) begin
            slot      = hit_slot;
            touch_lim = lrupr_pkg::COUNT_W'(eff_age[hit_slot]);
        end else if (do_fill) begin
            slot      = free_slot;
            touch_lim = resident;
        end else begin
            slot      = lru_slot;
            touch_lim = lrupr_pkg::COUNT_W'(eff_age[lru_slot]);
        end

        for (int i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
            n_valid[i] = eff_valid[i] || (do_fill && slot == lrupr_pkg::SLOT_W'(i));
            if (do_touch && slot == lrupr_pkg::SLOT_W'(i)) begin
                n_age[i] = '0;
            end else if (do_touch && eff_valid[i]
                         && lrupr_pkg::COUNT_W'(eff_age[i]) < touch_lim) begin
                n_age[i] = eff_age[i] + 1'b1;
            end else begin
                n_age[i] = eff_age[i];
            end
        end

        if (hit_any || eff_fault == '1) begin
            n_fault = eff_fault;
        end else begin
            n_fault = eff_fault + 1'b1;
        end

        n_victim_page = do_evict ? lrupr_pkg::PAGE_NUM_W'(r_page[lru_slot]) : '0;
    end

    // Frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fault <= '0;
            for (int i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
                r_age[i] <= '0;
            end
        end else if (process) begin
            r_valid <= n_valid;
            r_fault <= n_fault;
            for (int i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
                r_age[i] <= n_age[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && (do_fill || do_evict)) begin
            r_page[slot] <= r_in_page;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_fault        <= !hit_any;
            r_out_victim_valid <= do_evict;
            r_out_victim_page  <= n_victim_page;
            r_out_count        <= n_fault;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_page_fault   = r_out_fault;
    assign o_victim_valid = r_out_victim_valid;
    assign o_victim_page  = r_out_victim_page;
    assign o_fault_count  = r_out_count;

endmodule

// ----- hw/rtl/lrupr_checker.sv -----
// Port-level assertion checker for the LRU page replacement block and its bind.
`include "lru_page_replacement_macros.svh"

module lrupr_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 o_in_stall,
    input  logic [lrupr_pkg::PAGE_NUM_W-1:0]     i_page_number,
    input  logic                                 i_start_run,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    input  logic                                 o_page_fault,
    input  logic                                 o_victim_valid,
    input  logic [lrupr_pkg::PAGE_NUM_W-1:0]     o_victim_page,
    input  logic [lrupr_pkg::FAULT_W-1:0]        o_fault_count,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lrupr_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lrupr_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic [lrupr_pkg::APB_DATA_W-1:0]     prdata,
    input  logic                                 pready
);

    // A stalled result keeps its valid and its payload.
    `LRUPR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_page_fault) && $stable(o_victim_valid) && $stable(o_victim_page) && $stable(o_fault_count))

    // An eviction only happens on a fault.
    `LRUPR_ASSERT_SAME(a_victim_fault, i_clk, i_rst_n, o_out_valid && o_victim_valid, o_page_fault)

    // Without an eviction the victim page reads as zero.
    `LRUPR_ASSERT_SAME(a_victim_zero, i_clk, i_rst_n, o_out_valid && !o_victim_valid, o_victim_page == '0)

    // A faulting request always leaves a nonzero fault count.
    `LRUPR_ASSERT_SAME(a_fault_count, i_clk, i_rst_n, o_out_valid && o_page_fault, o_fault_count != '0)

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);

// ----- tb/lru_checker.sv -----
// Checker that predicts and compares the results of the LRU page replacement block.
`timescale 1ns / 1ps
module lru_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [lrupr_pkg::PAGE_NUM_W-1:0] i_page_number,
    input  logic                             i_start_run,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic                             i_page_fault,
    input  logic                             i_victim_valid,
    input  logic [lrupr_pkg::PAGE_NUM_W-1:0] i_victim_page,
    input  logic [lrupr_pkg::FAULT_W-1:0]    i_fault_count,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [lrupr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lrupr_pkg::APB_DATA_W-1:0] pwdata,
    output int                               o_fail_count,
    output int                               o_pending
);
    import lrupr_pkg::*;

    typedef struct packed {
        logic   fault;
        logic   evicted;
        t_page  victim;
        t_fault count;
    } t_page_outcome;

    t_page              frame_pg   [MAX_FRAMES];
    logic               frame_used [MAX_FRAMES];
    int unsigned        frame_rank [MAX_FRAMES];
    t_fault             fault_total;
    logic [LIMIT_W-1:0] frame_limit;
    t_page_outcome      outcome_q [$];
    int                 fails = 0;

    function automatic void clear_frames();
        for (int i = 0; i < MAX_FRAMES; i++) begin
            frame_pg[i]   = '0;
            frame_used[i] = 1'b0;
            frame_rank[i] = 0;
        end
        fault_total = '0;
    endfunction

    // Makes a frame the most recent; resident frames younger than the bound grow one older.
    function automatic void make_recent(int slot, int unsigned bound);
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (i != slot && frame_used[i] && frame_rank[i] < bound) begin
                frame_rank[i]++;
            end
        end
        frame_rank[slot] = 0;
    endfunction

    function automatic t_page_outcome lookup_page(t_page page, logic clear);
        t_page_outcome res;
        int            hit;
        int            free_slot;
        int            lru;
        int unsigned   resident;
        int unsigned   cap;
        res       = '0;
        hit       = -1;
        free_slot = -1;
        lru       = -1;
        resident  = 0;
        if (clear) begin
            clear_frames();
        end
        cap = frame_limit;
        if (cap == 0) begin
            cap = 1;
        end
        if (cap > MAX_FRAMES) begin
            cap = MAX_FRAMES;
        end
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (frame_used[i]) begin
                resident++;
                if (frame_pg[i] == page) begin
                    hit = i;
                end
                if (lru < 0 || frame_rank[i] > frame_rank[lru]) begin
                    lru = i;
                end
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (hit >= 0) begin
            make_recent(hit, frame_rank[hit]);
        end else begin
            res.fault = 1'b1;
            if (fault_total != '1) begin
                fault_total++;
            end
            if (resident < cap && free_slot >= 0) begin
                frame_used[free_slot] = 1'b1;
                frame_pg[free_slot]   = page;
                make_recent(free_slot, 32'hFFFF_FFFF);
            end else if (lru >= 0) begin
                res.evicted   = 1'b1;
                res.victim    = frame_pg[lru];
                frame_pg[lru] = page;
                make_recent(lru, frame_rank[lru]);
            end
        end
        res.count = fault_total;
        return res;
    endfunction

    task automatic check_field(string name, logic [FAULT_W-1:0] want, logic [FAULT_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_page_outcome want;
        if (!i_rst_n) begin
            clear_frames();
            frame_limit = FRAMES_RESET;
            outcome_q.delete();
        end else begin
            if (psel && penable && pwrite && pready
                && paddr[APB_ADDR_W-1:2] == REG_FRAMES_IN_USE) begin
                frame_limit = pwdata[LIMIT_W-1:0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (outcome_q.size() == 0) begin
                    $error("Result accepted with no request outstanding.");
                    fails++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("page_fault", want.fault, i_page_fault);
                    check_field("victim_valid", want.evicted, i_victim_valid);
                    check_field("victim_page", want.victim, i_victim_page);
                    check_field("fault_count", want.count, i_fault_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                outcome_q = {outcome_q, lookup_page(t_page'(i_page_number), i_start_run)};
            end
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= fails;
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the testbench: drives requests and register writes and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
    import lrupr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 38;
    localparam int POOL_MAX       = 12;

    localparam logic [APB_ADDR_W-1:0] ADDR_FRAMES_IN_USE =
        APB_ADDR_W'(int'(REG_FRAMES_IN_USE) * 4);
    localparam logic [APB_ADDR_W-1:0] ADDR_NO_REG =
        APB_ADDR_W'((int'(REG_FRAMES_IN_USE) + 1) * 4);

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [PAGE_NUM_W-1:0] i_page_number;
    logic                  i_start_run;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_page_fault;
    logic                  o_victim_valid;
    logic [PAGE_NUM_W-1:0] o_victim_page;
    logic [FAULT_W-1:0]    o_fault_count;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    bit idle_on = 1'b1;
    int stall_left = 0;

    lru_page_replacement u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_page_number  (i_page_number),
        .i_start_run    (i_start_run),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_page_fault   (o_page_fault),
        .o_victim_valid (o_victim_valid),
        .o_victim_page  (o_victim_page),
        .o_fault_count  (o_fault_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    lru_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_page_number  (i_page_number),
        .i_start_run    (i_start_run),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_page_fault   (o_page_fault),
        .i_victim_valid (o_victim_valid),
        .i_victim_page  (o_victim_page),
        .i_fault_count  (o_fault_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 3) == 0) begin
                stall_left <= pick_gap();
            end
        end
    end

    // Valid stays high after acceptance and is only lowered when a gap follows.
    task automatic send_req(input t_page page, input logic start);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_page_number <= page;
        i_start_run   <= start;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || psel || (i_in_valid && !o_in_stall)
                || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        t_page              pool [POOL_MAX];
        t_page              page;
        int                 pool_n;
        logic [LIMIT_W-1:0] lim;
        logic [APB_DATA_W-1:0] data;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_page_number = '0;
        i_start_run   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill all frames at the reset limit, hit, then evict in recency order.
        send_req(16'h0000, 1'b1);
        send_req(16'hFFFF, 1'b0);
        for (int k = 1; k <= 6; k++) begin
            send_req(t_page'(k), 1'b0);
        end
        send_req(16'h0000, 1'b0);
        send_req(16'h0007, 1'b0);
        send_req(16'hFFFF, 1'b0);

        // A zero limit acts as one, and lowering it keeps every resident page.
        write_reg(ADDR_FRAMES_IN_USE, 32'h0000_0000);
        send_req(16'h0008, 1'b0);
        send_req(16'h0008, 1'b0);

        // A write to an address with no register is ignored; a limit past capacity is capped.
        write_reg(ADDR_NO_REG, 32'h0000_0003);
        write_reg(ADDR_FRAMES_IN_USE, 32'hFFFF_FFFF);
        send_req(16'h5555, 1'b1);
        send_req(16'hAAAA, 1'b0);

        write_reg(ADDR_FRAMES_IN_USE, 32'h0000_0001);
        send_req(16'h1234, 1'b1);
        send_req(16'h1234, 1'b0);
        send_req(16'h4321, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       lim = 4'd0;
                1:       lim = 4'd1;
                2:       lim = 4'd8;
                3:       lim = 4'd15;
                default: lim = LIMIT_W'($urandom_range(0, 15));
            endcase
            data = $urandom();
            data[LIMIT_W-1:0] = lim;
            if (p % 4 == 1) begin
                write_reg(ADDR_NO_REG, $urandom());
            end
            write_reg(ADDR_FRAMES_IN_USE, data);
            idle_on = (p % 5 != 3);
            pool_n = $urandom_range(2, POOL_MAX);
            for (int k = 0; k < pool_n; k++) begin
                pool[k] = t_page'($urandom());
            end
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                if ($urandom_range(0, 4) == 0) begin
                    page = t_page'($urandom());
                end else begin
                    page = pool[$urandom_range(0, pool_n - 1)];
                end
                send_req(page, (j == 0 && p % 3 == 0) || $urandom_range(0, 39) == 0);
            end
        end
        idle_on = 1'b1;

        wait_idle();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
